### design/adsf_pkg.sv
// ----------------------------------------------------------------------------
// adsf_pkg
// shared constants, register map, mode codes and pipeline control types
// ----------------------------------------------------------------------------
package adsf_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int VOL_W     = 7;
  localparam int MAG_W     = 22;
  localparam int RECIP_W   = 23;
  localparam int WIDE_W    = MAG_W + RECIP_W;
  localparam int SCALED_W  = SAMPLE_W + 1;
  localparam int ADDR_W    = 4;

  localparam logic [VOL_W-1:0]    VOLUME_FULL = 7'd100;
  // ceil(2^29 / 100), exact floor division for magnitudes below 2^22
  localparam int                  RECIP_SHIFT = 29;
  localparam logic [RECIP_W-1:0]  RECIP_MULT  = 23'd5368710;

  localparam logic [SAMPLE_W-1:0] DAC_OFFSET  = 16'h8000;
  localparam logic signed [SCALED_W-1:0] DIFF_KNEE_POS = 17'sd32512;
  localparam logic signed [SCALED_W-1:0] DIFF_KNEE_NEG = -17'sd32512;
  localparam logic [SAMPLE_W-1:0] DIFF_STEP   = 16'h0100;
  localparam logic [SAMPLE_W-1:0] DIFF_HI_R   = 16'hFF00;
  localparam logic [SAMPLE_W-1:0] DIFF_LO_R   = 16'h0100;

  localparam logic [1:0] REG_VOLUME = 2'd0;
  localparam logic [1:0] REG_MUTE   = 2'd1;
  localparam logic [1:0] REG_MODE   = 2'd2;

  typedef enum logic [1:0] {
    MODE_EXTERNAL = 2'd0,
    MODE_LEFT     = 2'd1,
    MODE_RIGHT    = 2'd2,
    MODE_DIFF     = 2'd3
  } out_mode_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } adsf_adv_t;

endpackage

### design/audio_dac_sample_formatter.sv
// ----------------------------------------------------------------------------
// audio_dac_sample_formatter
// stereo frame scaling and dac word formatting with an apb register port
// ----------------------------------------------------------------------------
// Four-stage pipeline, one stereo frame per clock: abs and volume multiply,
// reciprocal multiply for the divide by 100, sign restore, then mono mixdown
// and mode formatting into the output register. Each stage holds only
// while the one after it is full and stalled, so bubbles close up under
// back-pressure. Registers: volume_percent at 0x0 (values above 100 act
// as 100), mute at 0x4, output_mode at 0x8 (0 external, 1 internal left,
// 2 internal right, 3 differential). Change registers only while the
// pipeline is empty.
module audio_dac_sample_formatter
  import adsf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // apb
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // input stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [31:0]       s_axis_tdata,   // left_in [15:0], right_in [31:16]
  // output stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [31:0]       m_axis_tdata    // left_out [15:0], right_out [31:16]
);

  logic [VOL_W-1:0]  volume_percent;
  logic              mute;
  out_mode_t         output_mode;
  logic              cfg_wr;
  logic [VOL_W-1:0]  vol_eff;

  logic              v1;
  logic              v2;
  logic              v3;
  logic              adv_out;
  logic              adv_s1;
  logic              adv_s2;
  logic              adv_s3;
  adsf_adv_t         adv;

  logic signed [SCALED_W-1:0] left_s;
  logic signed [SCALED_W-1:0] right_s;
  logic signed [SCALED_W:0]   sum;
  logic signed [SCALED_W-1:0] mono;
  logic [SAMPLE_W-1:0]        left_next;
  logic [SAMPLE_W-1:0]        right_next;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      volume_percent <= '0;
      mute           <= 1'b0;
      output_mode    <= MODE_EXTERNAL;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_VOLUME: volume_percent <= pwdata[VOL_W-1:0];
        REG_MUTE:   mute           <= pwdata[0];
        REG_MODE:   output_mode    <= out_mode_t'(pwdata[1:0]);
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_VOLUME: prdata = {{(32-VOL_W){1'b0}}, volume_percent};
      REG_MUTE:   prdata = {31'd0, mute};
      REG_MODE:   prdata = {30'd0, output_mode};
      default:    prdata = '0;
    endcase
  end

  assign vol_eff = mute ? '0 : ((volume_percent > VOLUME_FULL) ? VOLUME_FULL : volume_percent);

  // pipeline advance chain
  assign adv_out       = !m_axis_tvalid || m_axis_tready;
  assign adv_s3        = !v3 || adv_out;
  assign adv_s2        = !v2 || adv_s3;
  assign adv_s1        = !v1 || adv_s2;
  assign adv           = '{s1: adv_s1, s2: adv_s2, s3: adv_s3};
  assign s_axis_tready = adv_s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1            <= 1'b0;
      v2            <= 1'b0;
      v3            <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (adv_s1)  v1            <= s_axis_tvalid;
      if (adv_s2)  v2            <= v1;
      if (adv_s3)  v3            <= v2;
      if (adv_out) m_axis_tvalid <= v3;
    end
  end

  adsf_scale u_scale_left (
    .clk    (clk),
    .adv    (adv),
    .sample (s_axis_tdata[15:0]),
    .vol    (vol_eff),
    .scaled (left_s)
  );

  adsf_scale u_scale_right (
    .clk    (clk),
    .adv    (adv),
    .sample (s_axis_tdata[31:16]),
    .vol    (vol_eff),
    .scaled (right_s)
  );

  // mono mixdown and formatting
  assign sum  = {left_s[SCALED_W-1], left_s} + {right_s[SCALED_W-1], right_s};
  assign mono = sum[SCALED_W:1];

  always_comb begin
    case (output_mode)
      MODE_EXTERNAL: begin
        left_next  = left_s[SAMPLE_W-1:0];
        right_next = right_s[SAMPLE_W-1:0];
      end
      MODE_LEFT: begin
        left_next  = mono[SAMPLE_W-1:0] ^ DAC_OFFSET;
        right_next = '0;
      end
      MODE_RIGHT: begin
        left_next  = '0;
        right_next = mono[SAMPLE_W-1:0] ^ DAC_OFFSET;
      end
      MODE_DIFF: begin
        if (mono > DIFF_KNEE_POS) begin
          left_next  = mono[SAMPLE_W-1:0] + DIFF_STEP;
          right_next = DIFF_HI_R;
        end else if (mono < DIFF_KNEE_NEG) begin
          left_next  = mono[SAMPLE_W-1:0] - DIFF_STEP;
          right_next = DIFF_LO_R;
        end else begin
          left_next  = DAC_OFFSET;
          right_next = mono[SAMPLE_W-1:0] ^ DAC_OFFSET;
        end
      end
      default: begin
        left_next  = '0;
        right_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      m_axis_tdata <= {right_next, left_next};
    end
  end

  // checks
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> v1)
    else $error("accepted request did not enter first stage");

  a_empty_s1_ready: assert property (@(posedge clk) disable iff (rst)
    !v1 |-> s_axis_tready)
    else $error("input stalled with empty first stage");

  a_stalled_s2_holds: assert property (@(posedge clk) disable iff (rst)
    v2 && !adv_s3 |=> v2)
    else $error("stalled stage two lost its request");

  a_s3_reaches_out: assert property (@(posedge clk) disable iff (rst)
    v3 && adv_out |=> m_axis_tvalid)
    else $error("stage three request did not reach output");

endmodule

### design/adsf_scale.sv
// ----------------------------------------------------------------------------
// adsf_scale
// three-stage channel scaler: sample * volume / 100, truncated toward zero
// ----------------------------------------------------------------------------
module adsf_scale
  import adsf_pkg::*;
(
  input  logic                       clk,
  input  adsf_adv_t                  adv,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic [VOL_W-1:0]           vol,
  output logic signed [SCALED_W-1:0] scaled
);

  logic [SAMPLE_W-1:0]          mag;
  logic [MAG_W-1:0]             prod_full;
  logic [MAG_W-1:0]             prod;
  logic                         sign1;
  logic [WIDE_W-1:0]            wide;
  logic [SAMPLE_W-1:0]          quot;
  logic                         sign2;
  logic [SCALED_W-1:0]          quot_ext;

  assign mag       = sample[SAMPLE_W-1] ? SAMPLE_W'(-sample) : sample;
  assign prod_full = MAG_W'(mag) * MAG_W'(vol);

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      prod  <= prod_full;
      sign1 <= sample[SAMPLE_W-1];
    end
  end

  assign wide = WIDE_W'(prod) * WIDE_W'(RECIP_MULT);

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      quot  <= wide[RECIP_SHIFT+SAMPLE_W-1:RECIP_SHIFT];
      sign2 <= sign1;
    end
  end

  assign quot_ext = {1'b0, quot};

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      scaled <= sign2 ? -$signed(quot_ext) : $signed(quot_ext);
    end
  end

endmodule
